// ----- src/sensor_range_to_world_point_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the range-to-world-point block
// Checks are clocked on aclk; the first form is off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef SENSOR_RANGE_TO_WORLD_POINT_TOP_MACROS_SVH
`define SENSOR_RANGE_TO_WORLD_POINT_TOP_MACROS_SVH

// Check that holds in normal operation.
`define SRWP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check that also holds across reset.
`define SRWP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- src/srwp_pkg.sv -----
// ----------------------------------------------------------------------------
// srwp_pkg
// Shared widths, register codes, types and the quarter-wave sine table.
// ----------------------------------------------------------------------------
package srwp_pkg;

    localparam int ANGLE_BITS     = 12;
    localparam int TRIG_FRAC_BITS = 15;

    localparam int QTR    = 1 << (ANGLE_BITS - 2);
    localparam int IDX_W  = ANGLE_BITS - 1;        // table index, 0..QTR
    localparam int TRIG_W = TRIG_FRAC_BITS + 2;    // signed trig value

    localparam int RANGE_W       = 16;
    localparam int POS_W         = 24;
    localparam int MOUNT_W       = 16;
    localparam int MOUNT_ANGLE_W = 12;
    localparam int HEAD_ANGLE_W  = 12;
    localparam int OUT_W         = 26;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Datapath widths
    localparam int PX_W   = TRIG_FRAC_BITS + 18;   // robot-frame point, F frac bits
    localparam int PROD_W = PX_W + TRIG_W;         // point times trig, 2F frac bits
    localparam int SUM_W  = PROD_W + 1;
    localparam int RND_W  = SUM_W - 2 * TRIG_FRAC_BITS;

    localparam logic signed [SUM_W-1:0] RND_HALF =
        {{(SUM_W-1){1'b0}}, 1'b1} << (2 * TRIG_FRAC_BITS - 1);

    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MOUNT_X     = 2'd0,
        CFG_MOUNT_Y     = 2'd1,
        CFG_MOUNT_ANGLE = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic signed [TRIG_W-1:0] sin_v;
        logic signed [TRIG_W-1:0] cos_v;
    } sincos_t;

    typedef struct packed {
        logic signed [POS_W-1:0] rx;
        logic signed [POS_W-1:0] ry;
    } pos_t;

    typedef logic [TRIG_FRAC_BITS:0] trig_mag_t;
    typedef trig_mag_t trig_rom_t [QTR+1];

    localparam longint unsigned PI_Q30       = 64'd3373259426;
    localparam int              TAYLOR_TERMS = 10;

    // Series numerators stay below 2^33 (x < 2^31, x^2 >> 30 < 2^32).
    localparam int SERIES_NUM_W = 34;

    // Shift-and-subtract quotient, used only while building the table.
    function automatic longint unsigned series_quot(longint unsigned num,
                                                    longint unsigned den);
        longint unsigned q;
        longint unsigned rem;
        q   = '0;
        rem = '0;
        for (int b = SERIES_NUM_W - 1; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem  = rem - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // sin(k*pi/(2*QTR)) for k = 0..QTR, Taylor series in Q30, rounded to F bits.
    function automatic trig_rom_t build_trig_rom();
        trig_rom_t       tab;
        longint unsigned kk;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned r;
        longint unsigned one;
        longint unsigned den;
        longint          s;
        one = 64'd1 << TRIG_FRAC_BITS;
        for (int k = 0; k <= QTR; k++) begin
            kk = 64'(k);
            x  = (kk * PI_Q30 + (64'd1 << (ANGLE_BITS - 2))) >> (ANGLE_BITS - 1);
            x2 = (x * x) >> 30;
            t  = x;
            s  = signed'(x);
            for (int n = 1; n <= TAYLOR_TERMS; n++) begin
                den = 64'((2 * n) * (2 * n + 1));
                t   = series_quot((t * x2) >> 30, den);
                if ((n & 1) == 1) begin
                    s = s - signed'(t);
                end else begin
                    s = s + signed'(t);
                end
            end
            if (s < 0) begin
                s = 0;
            end
            r = (unsigned'(s) + (64'd1 << (29 - TRIG_FRAC_BITS))) >> (30 - TRIG_FRAC_BITS);
            if (r > one) begin
                r = one;
            end
            tab[k] = trig_mag_t'(r);
        end
        return tab;
    endfunction

endpackage

// ----- src/srwp_trig_rom.sv -----
// ----------------------------------------------------------------------------
// srwp_trig_rom
// Quarter-wave sine table, two read ports, registered read data.
// ----------------------------------------------------------------------------
module srwp_trig_rom
    import srwp_pkg::*;
(
    input  logic             aclk,
    input  logic             en,
    input  logic [IDX_W-1:0] addr_a,
    input  logic [IDX_W-1:0] addr_b,
    output trig_mag_t        data_a,
    output trig_mag_t        data_b
);

    localparam trig_rom_t TRIG_ROM = build_trig_rom();

    trig_mag_t data_a_reg;
    trig_mag_t data_b_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            data_a_reg <= TRIG_ROM[addr_a];
            data_b_reg <= TRIG_ROM[addr_b];
        end
    end

    assign data_a = data_a_reg;
    assign data_b = data_b_reg;

endmodule

// ----- src/srwp_sincos.sv -----
// ----------------------------------------------------------------------------
// srwp_sincos
// Sine and cosine of a binary angle: table read, then quadrant sign.
// Table data and signed result are registered; advances on en.
// ----------------------------------------------------------------------------
module srwp_sincos
    import srwp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  en,
    input  logic [ANGLE_BITS-1:0] angle,
    output sincos_t               sc
);

    logic [1:0]              quad;
    logic [IDX_W-1:0]        k_ext;
    logic [IDX_W-1:0]        k_mirror;
    logic [IDX_W-1:0]        sin_idx;
    logic [IDX_W-1:0]        cos_idx;
    trig_mag_t               sin_mag;
    trig_mag_t               cos_mag;
    logic                    sin_neg_reg;
    logic                    cos_neg_reg;
    logic signed [TRIG_W-1:0] sin_ext;
    logic signed [TRIG_W-1:0] cos_ext;
    sincos_t                 sc_next;
    sincos_t                 sc_reg;

    // Odd quadrants read the table mirrored; cos is sin one quadrant on.
    assign quad     = angle[ANGLE_BITS-1 -: 2];
    assign k_ext    = {1'b0, angle[ANGLE_BITS-3:0]};
    assign k_mirror = IDX_W'(QTR) - k_ext;
    assign sin_idx  = quad[0] ? k_mirror : k_ext;
    assign cos_idx  = quad[0] ? k_ext : k_mirror;

    srwp_trig_rom u_rom (
        .aclk   (aclk),
        .en     (en),
        .addr_a (sin_idx),
        .addr_b (cos_idx),
        .data_a (sin_mag),
        .data_b (cos_mag)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            sin_neg_reg <= quad[1];
            cos_neg_reg <= quad[1] ^ quad[0];
        end
    end

    assign sin_ext = signed'({1'b0, sin_mag});
    assign cos_ext = signed'({1'b0, cos_mag});

    always_comb begin
        sc_next.sin_v = sin_neg_reg ? -sin_ext : sin_ext;
        sc_next.cos_v = cos_neg_reg ? -cos_ext : cos_ext;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sc_reg <= sc_next;
        end
    end

    assign sc = sc_reg;

endmodule

// ----- src/srwp_transform.sv -----
// ----------------------------------------------------------------------------
// srwp_transform
// Beam point plus mount offset, rotation by heading, rounding to mm.
// Four stages: point, products, sums, rounding.
// ----------------------------------------------------------------------------
module srwp_transform
    import srwp_pkg::*;
(
    input  logic                       aclk,
    input  logic                       en,
    input  logic [RANGE_W-1:0]         range_mm,
    input  logic signed [MOUNT_W-1:0]  mount_x,
    input  logic signed [MOUNT_W-1:0]  mount_y,
    input  sincos_t                    sc_mount,
    input  sincos_t                    sc_head,
    output logic signed [RND_W-1:0]    off_x,
    output logic signed [RND_W-1:0]    off_y
);

    logic signed [RANGE_W:0]              range_s;
    logic signed [TRIG_W-1:0]             cm;
    logic signed [TRIG_W-1:0]             sm;
    logic signed [RANGE_W+TRIG_W-1:0]     rc;
    logic signed [RANGE_W+TRIG_W-1:0]     rs;
    logic signed [PX_W-1:0]               mx_s;
    logic signed [PX_W-1:0]               my_s;
    logic signed [PX_W-1:0]               px_next, py_next;
    logic signed [PX_W-1:0]               px_reg, py_reg;
    logic signed [TRIG_W-1:0]             ch_next, sh_next;
    logic signed [TRIG_W-1:0]             ch_reg, sh_reg;

    logic signed [PROD_W-1:0]             pxc_next, pys_next, pxs_next, pyc_next;
    logic signed [PROD_W-1:0]             pxc_reg, pys_reg, pxs_reg, pyc_reg;

    logic signed [SUM_W-1:0]              ex_next, ey_next;
    logic signed [SUM_W-1:0]              ex_reg, ey_reg;
    logic signed [SUM_W-1:0]              adj_x, adj_y;
    logic signed [RND_W-1:0]              off_x_next, off_y_next;
    logic signed [RND_W-1:0]              off_x_reg, off_y_reg;

    // Point in robot frame, F fraction bits
    assign range_s = signed'({1'b0, range_mm});
    assign cm      = sc_mount.cos_v;
    assign sm      = sc_mount.sin_v;
    assign rc      = range_s * cm;
    assign rs      = range_s * sm;
    assign mx_s    = PX_W'(mount_x) <<< TRIG_FRAC_BITS;
    assign my_s    = PX_W'(mount_y) <<< TRIG_FRAC_BITS;
    assign px_next = PX_W'(rc) + mx_s;
    assign py_next = PX_W'(rs) + my_s;
    assign ch_next = sc_head.cos_v;
    assign sh_next = sc_head.sin_v;

    always_ff @(posedge aclk) begin
        if (en) begin
            px_reg <= px_next;
            py_reg <= py_next;
            ch_reg <= ch_next;
            sh_reg <= sh_next;
        end
    end

    // Rotation products, 2F fraction bits
    assign pxc_next = px_reg * ch_reg;
    assign pys_next = py_reg * sh_reg;
    assign pxs_next = px_reg * sh_reg;
    assign pyc_next = py_reg * ch_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            pxc_reg <= pxc_next;
            pys_reg <= pys_next;
            pxs_reg <= pxs_next;
            pyc_reg <= pyc_next;
        end
    end

    assign ex_next = SUM_W'(pxc_reg) - SUM_W'(pys_reg);
    assign ey_next = SUM_W'(pxs_reg) + SUM_W'(pyc_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            ex_reg <= ex_next;
            ey_reg <= ey_next;
        end
    end

    // Half away from zero: add half, less one when negative, then floor.
    assign adj_x      = ex_reg + RND_HALF - SUM_W'(ex_reg[SUM_W-1]);
    assign adj_y      = ey_reg + RND_HALF - SUM_W'(ey_reg[SUM_W-1]);
    assign off_x_next = signed'(adj_x[SUM_W-1 -: RND_W]);
    assign off_y_next = signed'(adj_y[SUM_W-1 -: RND_W]);

    always_ff @(posedge aclk) begin
        if (en) begin
            off_x_reg <= off_x_next;
            off_y_reg <= off_y_next;
        end
    end

    assign off_x = off_x_reg;
    assign off_y = off_y_reg;

endmodule

// ----- src/sensor_range_to_world_point_top.sv -----
// ----------------------------------------------------------------------------
// sensor_range_to_world_point_top
// Range reading plus robot pose to a saturated world-frame point in mm.
//
//   Channel   Direction  Handshake          Payload (low bit first)
//   s_*       in         s_tvalid/s_tready  tdata: range_mm, robot_x, robot_y,
//                                           robot_angle, zero pad to 80 bits
//   m_*       out        m_tvalid/m_tready  tdata: world_x, world_y, pad to 56
//                                           tuser: clipped
//   cfg_*     in         cfg_wr_en          index 0 mount_x, 1 mount_y,
//                                           2 mount_angle
//
// One transfer per clock in and out while the output is not blocked; the
// path runs through the table read and sign, the point, product, sum and
// rounding stages, and the final add with saturation in the output register.
// aresetn (synchronous, active low) clears the pipeline valids and the mount
// registers. The whole pipeline holds while the output register is full and
// not taken; s_tready drops only then, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
`include "sensor_range_to_world_point_top_macros.svh"

module sensor_range_to_world_point_top
    import srwp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [15:0] range_mm, [39:16] robot_x, [63:40] robot_y, [75:64] robot_angle
    input  logic [79:0]           s_tdata,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [25:0] world_x, [51:26] world_y, [55:52] zero
    output logic [55:0]           m_tdata,
    // [0] clipped
    output logic [0:0]            m_tuser,

    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int PIPE_DEPTH = 7;   // valid stages, last one is the output
    localparam int POS_DEPTH  = 6;   // pose delay up to the final add

    typedef struct packed {
        logic signed [OUT_W-1:0] wx;
        logic signed [OUT_W-1:0] wy;
        logic                    clip;
    } out_t;

    // Mount configuration
    logic signed [MOUNT_W-1:0]       mount_x_reg;
    logic signed [MOUNT_W-1:0]       mount_y_reg;
    logic [MOUNT_ANGLE_W-1:0]        mount_angle_reg;

    // Input fields
    logic [RANGE_W-1:0]              in_range;
    pos_t                            in_pos;
    logic [HEAD_ANGLE_W-1:0]         in_angle;

    // Pipeline control
    logic                            adv;
    logic [PIPE_DEPTH-1:0]           vld_reg;
    logic [PIPE_DEPTH-1:0]           vld_next;

    // Payload carried beside the datapath
    logic [RANGE_W-1:0]              range_d1_reg;
    logic [RANGE_W-1:0]              range_d2_reg;
    pos_t                            pos_pipe_reg [POS_DEPTH];

    sincos_t                         sc_mount;
    sincos_t                         sc_head;
    logic signed [RND_W-1:0]         off_x;
    logic signed [RND_W-1:0]         off_y;

    logic signed [OUT_W:0]           sum_x;
    logic signed [OUT_W:0]           sum_y;
    logic                            ovf_x;
    logic                            ovf_y;
    out_t                            out_next;
    out_t                            out_reg;

    assign in_range = s_tdata[15:0];
    assign in_pos.rx = signed'(s_tdata[39:16]);
    assign in_pos.ry = signed'(s_tdata[63:40]);
    assign in_angle  = s_tdata[75:64];

    // ---- configuration writes ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mount_x_reg     <= '0;
            mount_y_reg     <= '0;
            mount_angle_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                CFG_MOUNT_X:     mount_x_reg     <= signed'(cfg_wdata[MOUNT_W-1:0]);
                CFG_MOUNT_Y:     mount_y_reg     <= signed'(cfg_wdata[MOUNT_W-1:0]);
                CFG_MOUNT_ANGLE: mount_angle_reg <= cfg_wdata[MOUNT_ANGLE_W-1:0];
                default: ;   // unknown index, write dropped
            endcase
        end
    end

    // ---- pipeline advance: hold everything only on a blocked output ----
    assign adv      = !vld_reg[PIPE_DEPTH-1] || m_tready;
    assign s_tready = adv;
    assign vld_next = {vld_reg[PIPE_DEPTH-2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= vld_next;
        end
    end

    // ---- side payload ----
    always_ff @(posedge aclk) begin
        if (adv) begin
            range_d1_reg    <= in_range;
            range_d2_reg    <= range_d1_reg;
            pos_pipe_reg[0] <= in_pos;
            for (int i = 1; i < POS_DEPTH; i++) begin
                pos_pipe_reg[i] <= pos_pipe_reg[i-1];
            end
        end
    end

    // ---- stages 1-2: sine and cosine of mount and heading ----
    srwp_sincos u_sc_mount (
        .aclk  (aclk),
        .en    (adv),
        .angle (ANGLE_BITS'(mount_angle_reg)),
        .sc    (sc_mount)
    );

    srwp_sincos u_sc_head (
        .aclk  (aclk),
        .en    (adv),
        .angle (ANGLE_BITS'(in_angle)),
        .sc    (sc_head)
    );

    // ---- stages 3-6: point, rotation, rounding ----
    srwp_transform u_xform (
        .aclk     (aclk),
        .en       (adv),
        .range_mm (range_d2_reg),
        .mount_x  (mount_x_reg),
        .mount_y  (mount_y_reg),
        .sc_mount (sc_mount),
        .sc_head  (sc_head),
        .off_x    (off_x),
        .off_y    (off_y)
    );

    // ---- stage 7: add robot position, saturate to 26 bits ----
    assign sum_x = (OUT_W+1)'(off_x) + (OUT_W+1)'(pos_pipe_reg[POS_DEPTH-1].rx);
    assign sum_y = (OUT_W+1)'(off_y) + (OUT_W+1)'(pos_pipe_reg[POS_DEPTH-1].ry);
    assign ovf_x = sum_x[OUT_W] ^ sum_x[OUT_W-1];
    assign ovf_y = sum_y[OUT_W] ^ sum_y[OUT_W-1];

    always_comb begin
        out_next.wx   = ovf_x ? (sum_x[OUT_W] ? OUT_MIN : OUT_MAX) : sum_x[OUT_W-1:0];
        out_next.wy   = ovf_y ? (sum_y[OUT_W] ? OUT_MIN : OUT_MAX) : sum_y[OUT_W-1:0];
        out_next.clip = ovf_x | ovf_y;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid   = vld_reg[PIPE_DEPTH-1];
    assign m_tdata    = {4'b0000, out_reg.wy, out_reg.wx};
    assign m_tuser[0] = out_reg.clip;

    // ---- checks ----
    `SRWP_ASSERT(a_stall_only_on_output, !s_tready |-> (m_tvalid && !m_tready), "input stalled without output backpressure")
    `SRWP_ASSERT(a_accept_enters_pipe, (s_tvalid && s_tready) |=> vld_reg[0], "accepted transfer missing from first stage")
    `SRWP_ASSERT(a_clip_at_bound, (m_tvalid && m_tuser[0]) |-> (out_reg.wx == OUT_MIN || out_reg.wx == OUT_MAX || out_reg.wy == OUT_MIN || out_reg.wy == OUT_MAX), "clipped flag without a saturated coordinate")
    `SRWP_ASSERT_ALWAYS(a_reset_empties, !aresetn |=> (vld_reg == '0), "pipeline not empty after reset")

endmodule

// ----- tb/srwp_tb_pkg.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// srwp_tb_pkg
// Transfer types and the world-point scoreboard for the range-to-world bench.
// The scoreboard keeps its own mount registers and sine table and predicts
// one world point for every accepted reading.
// ----------------------------------------------------------------------------
package srwp_tb_pkg;

    import srwp_pkg::*;

    // Same layout as s_tdata[75:0], last member in the low bits
    typedef struct packed {
        logic [HEAD_ANGLE_W-1:0] robot_angle;
        logic signed [POS_W-1:0] robot_y;
        logic signed [POS_W-1:0] robot_x;
        logic [RANGE_W-1:0]      range_mm;
    } pose_reading_t;

    // {m_tuser[0], m_tdata[51:0]}
    typedef struct packed {
        logic                    clipped;
        logic signed [OUT_W-1:0] world_y;
        logic signed [OUT_W-1:0] world_x;
    } world_point_t;

    localparam longint unsigned HALF_TURN_Q30 = 64'd3373259426;
    localparam int              SERIES_TERMS  = 10;
    localparam longint          TRIG_ONE      = 64'sd1 << TRIG_FRAC_BITS;
    localparam int              PROD_SHIFT    = 2 * TRIG_FRAC_BITS;
    localparam longint          WORLD_MAX     = (64'sd1 << (OUT_W - 1)) - 1;
    localparam longint          WORLD_MIN     = -(64'sd1 << (OUT_W - 1));

    class world_point_scoreboard;

        longint       mount_x;
        longint       mount_y;
        int unsigned  mount_angle;
        longint       sine_lut [QTR+1];
        world_point_t pending_points [$];
        int           mismatch_count;

        function new();
            longint unsigned x;
            longint unsigned x2;
            longint unsigned term;
            longint unsigned rounded;
            longint          acc;
            mount_x        = 0;
            mount_y        = 0;
            mount_angle    = 0;
            mismatch_count = 0;
            // quarter-wave sine, Taylor series in Q30, rounded to F bits
            for (int k = 0; k <= QTR; k++) begin
                x    = (64'(k) * HALF_TURN_Q30 + (64'd1 << (ANGLE_BITS - 2)))
                       >> (ANGLE_BITS - 1);
                x2   = (x * x) >> 30;
                term = x;
                acc  = $signed(x);
                for (int n = 1; n <= SERIES_TERMS; n++) begin
                    term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
                    if ((n % 2) == 1) begin
                        acc = acc - $signed(term);
                    end else begin
                        acc = acc + $signed(term);
                    end
                end
                if (acc < 0) begin
                    acc = 0;
                end
                rounded = ($unsigned(acc) + (64'd1 << (29 - TRIG_FRAC_BITS)))
                          >> (30 - TRIG_FRAC_BITS);
                if (rounded > 64'(TRIG_ONE)) begin
                    rounded = 64'(TRIG_ONE);
                end
                sine_lut[k] = $signed(rounded);
            end
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_MOUNT_X:     mount_x = longint'($signed(data[MOUNT_W-1:0]));
                CFG_MOUNT_Y:     mount_y = longint'($signed(data[MOUNT_W-1:0]));
                CFG_MOUNT_ANGLE: mount_angle = data[MOUNT_ANGLE_W-1:0];
                default: ;  // unmapped index, write dropped
            endcase
        endfunction

        function longint sine_of(int unsigned a);
            int unsigned quad;
            int unsigned k;
            longint      v;
            a    = a & ((1 << ANGLE_BITS) - 1);
            quad = a >> (ANGLE_BITS - 2);
            k    = a & (QTR - 1);
            v    = ((quad & 1) != 0) ? sine_lut[QTR - k] : sine_lut[k];
            return ((quad & 2) != 0) ? -v : v;
        endfunction

        // round 2F fraction bits to whole mm, ties away from zero
        function longint round_mm(longint v);
            longint half;
            half = 64'sd1 <<< (PROD_SHIFT - 1);
            if (v < 0) begin
                return -((-v + half) >>> PROD_SHIFT);
            end
            return (v + half) >>> PROD_SHIFT;
        endfunction

        function longint clamp_world(longint v, inout bit clip);
            if (v > WORLD_MAX) begin
                clip = 1'b1;
                return WORLD_MAX;
            end
            if (v < WORLD_MIN) begin
                clip = 1'b1;
                return WORLD_MIN;
            end
            return v;
        endfunction

        function world_point_t predict_point(pose_reading_t rd);
            longint       rng;
            longint       cm;
            longint       sm;
            longint       ch;
            longint       sh;
            longint       px;
            longint       py;
            longint       ex;
            longint       ey;
            longint       wx;
            longint       wy;
            bit           clip;
            world_point_t pt;
            rng  = longint'(rd.range_mm);
            cm   = sine_of(mount_angle + QTR);
            sm   = sine_of(mount_angle);
            ch   = sine_of(int'(rd.robot_angle) + QTR);
            sh   = sine_of(int'(rd.robot_angle));
            px   = rng * cm + mount_x * TRIG_ONE;
            py   = rng * sm + mount_y * TRIG_ONE;
            ex   = px * ch - py * sh;
            ey   = px * sh + py * ch;
            clip = 1'b0;
            wx   = clamp_world(round_mm(ex) + longint'(rd.robot_x), clip);
            wy   = clamp_world(round_mm(ey) + longint'(rd.robot_y), clip);
            pt.world_x = OUT_W'(wx);
            pt.world_y = OUT_W'(wy);
            pt.clipped = clip;
            return pt;
        endfunction

        function void note_reading(pose_reading_t rd);
            pending_points.push_back(predict_point(rd));
        endfunction

        function void check_result(world_point_t got);
            world_point_t want;
            if (pending_points.size() == 0) begin
                $display("%0t: result with none pending: world_x %0d world_y %0d clipped %0d",
                         $time, got.world_x, got.world_y, got.clipped);
                mismatch_count++;
                return;
            end
            want = pending_points.pop_front();
            if (got.world_x !== want.world_x) begin
                $display("%0t: world_x expected %0d, actual %0d",
                         $time, want.world_x, got.world_x);
                mismatch_count++;
            end
            if (got.world_y !== want.world_y) begin
                $display("%0t: world_y expected %0d, actual %0d",
                         $time, want.world_y, got.world_y);
                mismatch_count++;
            end
            if (got.clipped !== want.clipped) begin
                $display("%0t: clipped expected %0d, actual %0d",
                         $time, want.clipped, got.clipped);
                mismatch_count++;
            end
        endfunction

    endclass

endpackage

// ----- tb/sensor_range_to_world_point_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sensor_range_to_world_point_top_tb
// Drives range readings with directed and random robot poses through the
// block under a series of mount settings and checks every world point, in
// order, against the scoreboard's prediction. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module sensor_range_to_world_point_top_tb;

    import srwp_pkg::*;
    import srwp_tb_pkg::*;

    // seven register stages from s_* to m_*
    localparam int PIPE_LATENCY = 7;
    localparam int NUM_PHASES   = 7;
    localparam int PHASE_ITEMS  = 85;

    // index past the last mount register; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

    localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

    // binary angles on and next to the quadrant edges
    localparam logic [HEAD_ANGLE_W-1:0] ANG_QTR  = 12'd1024;
    localparam logic [HEAD_ANGLE_W-1:0] ANG_HALF = 12'd2048;
    localparam logic [HEAD_ANGLE_W-1:0] ANG_3QTR = 12'd3072;
    localparam logic [HEAD_ANGLE_W-1:0] ANG_LAST = 12'd4095;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [79:0]           s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [55:0]           m_tdata;
    logic [0:0]            m_tuser;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // burst flags: while set, that side runs without idle cycles
    bit send_steady = 1'b0;
    bit recv_steady = 1'b0;

    world_point_scoreboard sb = new();

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    sensor_range_to_world_point_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Random idle cycles before the next transfer. Now and then a side flips
    // into or out of a gap-free burst, so long back-to-back runs happen too.
    function automatic int draw_wait(inout bit steady);
        if ($urandom_range(0, 19) == 0) begin
            steady = !steady;
        end
        return steady ? 0 : int'($urandom_range(0, 4));
    endfunction

    function automatic pose_reading_t make_reading(
        logic [RANGE_W-1:0] rng, logic signed [POS_W-1:0] rx,
        logic signed [POS_W-1:0] ry, logic [HEAD_ANGLE_W-1:0] ang);
        pose_reading_t rd;
        rd.range_mm    = rng;
        rd.robot_x     = rx;
        rd.robot_y     = ry;
        rd.robot_angle = ang;
        return rd;
    endfunction

    function automatic logic signed [POS_W-1:0] random_pos();
        case ($urandom_range(0, 9))
            0:       return POS_MAX;
            1:       return POS_MIN;
            2:       return POS_W'($signed($urandom_range(0, 2000)) - 1000);
            default: return POS_W'($urandom);
        endcase
    endfunction

    function automatic pose_reading_t random_reading();
        pose_reading_t rd;
        case ($urandom_range(0, 7))
            0:       rd.range_mm = '0;
            1:       rd.range_mm = '1;
            2:       rd.range_mm = RANGE_W'($urandom_range(0, 255));
            default: rd.range_mm = RANGE_W'($urandom);
        endcase
        rd.robot_x = random_pos();
        rd.robot_y = random_pos();
        // a quarter of the headings sit on or beside a quadrant edge
        case ($urandom_range(0, 15))
            0:       rd.robot_angle = '0;
            1:       rd.robot_angle = ANG_QTR;
            2:       rd.robot_angle = ANG_HALF;
            3:       rd.robot_angle = ANG_3QTR - 12'd1;
            default: rd.robot_angle = HEAD_ANGLE_W'($urandom);
        endcase
        return rd;
    endfunction

    // One input transfer. s_tvalid stays high into the next call when that
    // call draws no gap, so it is never dropped and raised in one step.
    task automatic send_reading(input pose_reading_t rd);
        int gap;
        gap = draw_wait(send_steady);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, rd};
        do @(posedge aclk); while (s_tready !== 1'b1);
        sb.note_reading(rd);
    endtask

    // Register write lands on the next edge; the caller drops cfg_wr_en.
    task automatic write_mount_reg(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.set_reg(idx, val);
    endtask

    // Every reading gives one point, so an empty queue means an empty
    // pipeline; the extra cycles cover the stages anyway.
    task automatic wait_drained();
        while (sb.pending_points.size() != 0) @(posedge aclk);
        repeat (PIPE_LATENCY + 3) @(posedge aclk);
    endtask

    task automatic program_mount(input int phase);
        case (phase)
            0: ;  // stay on reset values
            1: begin
                // most negative x, most positive y, angle wraps to 4095
                write_mount_reg(CFG_MOUNT_X, 16'h8000);
                write_mount_reg(CFG_MOUNT_Y, 16'h7FFF);
                write_mount_reg(CFG_MOUNT_ANGLE, 16'hFFFF);
                write_mount_reg(CFG_UNMAPPED, CFG_DATA_W'($urandom));
            end
            2: begin
                write_mount_reg(CFG_MOUNT_X, 16'h7FFF);
                write_mount_reg(CFG_MOUNT_Y, 16'h8000);
                write_mount_reg(CFG_MOUNT_ANGLE, 16'h0400);
            end
            3: begin
                // only bits above the angle width set: angle reads back as 0
                write_mount_reg(CFG_MOUNT_X, 16'h0000);
                write_mount_reg(CFG_MOUNT_Y, 16'h0000);
                write_mount_reg(CFG_MOUNT_ANGLE, 16'hF000);
            end
            default: begin
                write_mount_reg(CFG_MOUNT_X, CFG_DATA_W'($urandom));
                write_mount_reg(CFG_MOUNT_Y, CFG_DATA_W'($urandom));
                write_mount_reg(CFG_MOUNT_ANGLE, CFG_DATA_W'($urandom));
                write_mount_reg(CFG_UNMAPPED, CFG_DATA_W'($urandom));
            end
        endcase
        cfg_wr_en <= 1'b0;
    endtask

    // Field extremes and every quadrant. Positions at the limits push the
    // sums toward the output bounds; with these widths they stay inside, so
    // the clipped flag is expected low throughout.
    task automatic run_directed();
        send_reading(make_reading('0, '0, '0, '0));
        send_reading(make_reading('1, '0, '0, '0));
        send_reading(make_reading('1, '0, '0, ANG_QTR));
        send_reading(make_reading('1, '0, '0, ANG_HALF));
        send_reading(make_reading('1, '0, '0, ANG_3QTR));
        send_reading(make_reading('1, '0, '0, ANG_LAST));
        send_reading(make_reading(16'd1, '0, '0, 12'd1));
        send_reading(make_reading(16'd1000, '0, '0, 12'd512));
        send_reading(make_reading('1, POS_MAX, POS_MAX, 12'd512));
        send_reading(make_reading('1, POS_MIN, POS_MIN, 12'd2560));
        send_reading(make_reading('1, POS_MAX, POS_MIN, ANG_LAST));
        send_reading(make_reading(16'h5555, POS_MIN, POS_MAX, 12'hAAA));
    endtask

    // Stimulus: reset, then one phase per mount setting. Directed readings
    // go out under the reset and the extreme settings, random ones after.
    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            wait_drained();
            program_mount(phase);
            if (phase < 2) begin
                run_directed();
            end
            if (phase > 0) begin
                repeat (PHASE_ITEMS) send_reading(random_reading());
            end
            s_tvalid <= 1'b0;
        end
        wait_drained();
        if (sb.mismatch_count == 0 && sb.pending_points.size() == 0) begin
            $display("sensor_range_to_world_point_top_tb: done, clean");
        end else begin
            $display("sensor_range_to_world_point_top_tb: done, errors");
        end
        $finish;
    end

    // Result side: random back-pressure, one check per output transfer.
    initial begin
        int           stall;
        world_point_t got;
        @(posedge aclk);
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            stall = draw_wait(recv_steady);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            got = {m_tuser[0], m_tdata[2*OUT_W-1:0]};
            sb.check_result(got);
        end
    end

    // Watchdog: a few hundred readings finish far inside this limit.
    initial begin
        #2_000_000;
        $display("sensor_range_to_world_point_top_tb: done, errors");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+src
src/srwp_pkg.sv
src/srwp_trig_rom.sv
src/srwp_sincos.sv
src/srwp_transform.sv
src/sensor_range_to_world_point_top.sv
tb/srwp_tb_pkg.sv
tb/sensor_range_to_world_point_top_tb.sv
